// File: rtl/core/laplacian_four_neighbour_filter_top_assert.svh
// Assertion macros for the Laplacian filter; clocked on clk, held off during reset.
`ifndef LAPLACIAN_FOUR_NEIGHBOUR_FILTER_TOP_ASSERT_SVH
`define LAPLACIAN_FOUR_NEIGHBOUR_FILTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LPF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/lpf_pkg.sv
package lpf_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = 13;   // row count runs to height + 1 while draining
	localparam int PIX_W        = 8;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 12;
	localparam int CFG_DATA_W   = 12;
	localparam int CFG_IDX_W    = 2;
	localparam int SUM_W        = 11;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd540;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd360;
	localparam logic [WIDTH_REG_W-1:0]  MIN_WIDTH    = 11'd3;
	localparam logic [WIDTH_REG_W-1:0]  MAX_WIDTH_V  = WIDTH_REG_W'(MAX_WIDTH);
	localparam logic [HEIGHT_REG_W-1:0] MIN_HEIGHT   = 12'd2;

	localparam logic [PIX_W-1:0] LAP_OFFSET = 8'd128;
	localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

	// border flags of the pixel being finished
	typedef struct packed {
		logic l_zero;
		logic r_zero;
		logic u_zero;
		logic d_zero;
		logic last;
	} nbr_t;

	// last column index of the clamped width
	function automatic logic [COL_W-1:0] width_last(input logic [WIDTH_REG_W-1:0] w);
		logic [WIDTH_REG_W-1:0] wc;
		wc = w;
		if (wc < MIN_WIDTH)
			wc = MIN_WIDTH;
		if (wc > MAX_WIDTH_V)
			wc = MAX_WIDTH_V;
		return COL_W'(wc - WIDTH_REG_W'(1));
	endfunction

	function automatic logic [HEIGHT_REG_W-1:0] height_eff(input logic [HEIGHT_REG_W-1:0] h);
		return (h < MIN_HEIGHT) ? MIN_HEIGHT : h;
	endfunction

endpackage

// File: rtl/core/lpf_tap_cell.sv
module lpf_tap_cell import lpf_pkg::*; (
	input  logic             clk,
	input  logic             shift,
	input  logic             clear,
	input  logic [PIX_W-1:0] d,
	output logic [PIX_W-1:0] q
);

	logic [PIX_W-1:0] tap_q;

	always_ff @(posedge clk) begin
		if (clear) begin
			tap_q <= '0;
		end else if (shift) begin
			tap_q <= d;
		end
	end

	assign q = tap_q;

endmodule

// File: rtl/core/lpf_stencil.sv
module lpf_stencil import lpf_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic [PIX_W-1:0] centre,
	input  logic [PIX_W-1:0] left,
	input  logic [PIX_W-1:0] right,
	input  logic [PIX_W-1:0] up,
	input  logic [PIX_W-1:0] down,
	input  nbr_t             flags,
	output logic [PIX_W-1:0] filtered,
	output logic             frame_end
);

	logic [SUM_W-1:0] pos;
	logic [SUM_W-1:0] neg;
	logic [SUM_W-1:0] diff;
	logic [PIX_W-1:0] result;
	logic [PIX_W-1:0] filtered_s2;
	logic             frame_end_s2;

	// split into positive and negative parts so the clamp needs no sign
	always_comb begin
		pos = SUM_W'(LAP_OFFSET)
			+ (flags.l_zero ? '0 : SUM_W'(left))
			+ (flags.r_zero ? '0 : SUM_W'(right))
			+ (flags.u_zero ? '0 : SUM_W'(up))
			+ (flags.d_zero ? '0 : SUM_W'(down));
		neg  = SUM_W'({centre, 2'b00});
		diff = pos - neg;
		if (pos < neg) begin
			result = '0;
		end else if (diff > SUM_W'(PIX_MAX)) begin
			result = PIX_MAX;
		end else begin
			result = diff[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			filtered_s2  <= result;
			frame_end_s2 <= flags.last;
		end
	end

	assign filtered  = filtered_s2;
	assign frame_end = frame_end_s2;

endmodule

// File: rtl/core/laplacian_four_neighbour_filter_top.sv
// The result for pixel k is loaded into the output register as request k + W + 1 leaves stage s1
// (W = row width); W + 1 flush requests drain the last row.
// Throughput: one request per cycle unless output stalls; one read, one write port per line store.
// Reset: width 540, height 360, raster position and output valid cleared.
// Window, delays and line stores are not reset; a border pixel's missing neighbours are masked.
`include "laplacian_four_neighbour_filter_top_assert.svh"

module laplacian_four_neighbour_filter_top import lpf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel,
	input  logic                  flush,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      filtered,
	output logic                  frame_end,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [COL_W-1:0]        width_last_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [ROW_W-1:0]        height_ext;
	logic [ROW_W-1:0]        height_p1;

	logic in_acc;
	logic draining;
	logic use_item;
	logic col_first;
	logic produce_in;
	logic cfg_restart;
	nbr_t flags_in;

	logic             valid_s1;
	logic             produce_s1;
	nbr_t             flags_s1;
	logic [COL_W-1:0] col_s1;
	logic [PIX_W-1:0] px_s1;
	logic [PIX_W-1:0] cen_rd_s1;
	logic [PIX_W-1:0] abv_rd_s1;
	logic             s1_adv;
	logic             s1_ready;
	logic             win_clear;

	logic [PIX_W-1:0] up_q;
	logic [PIX_W-1:0] down_q;
	logic [PIX_W-1:0] centre_px;
	logic [PIX_W-1:0] left_px;
	logic             out_valid_q;

	logic             flush_drop;
	logic             restart_due;
	logic             pos_in_frame;

	logic [PIX_W-1:0] centre_mem [MAX_WIDTH];
	logic [PIX_W-1:0] above_mem  [MAX_WIDTH];

	assign height_ext = ROW_W'(height_q);
	assign height_p1  = height_ext + ROW_W'(1);
	assign draining   = row_q >= height_ext;
	assign in_acc     = in_valid && in_ready;
	// a flush inside the frame is taken and dropped
	assign use_item   = in_acc && (!flush || draining);
	assign col_first  = col_q == '0;
	assign cfg_restart = cfg_write &&
		(cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	// position of the finished pixel is one row up and one column behind, wrapping to the row before that
	always_comb begin
		produce_in     = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && !col_first);
		flags_in.l_zero = col_q == COL_W'(1);
		flags_in.r_zero = col_first;
		flags_in.u_zero = col_first ? (row_q == ROW_W'(2)) : (row_q == ROW_W'(1));
		flags_in.d_zero = col_first ? (row_q == height_p1) : (row_q == height_ext);
		flags_in.last   = col_first && (row_q == height_p1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q <= width_last(WIDTH_RESET);
			height_q     <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_last_q <= width_last(cfg_data[WIDTH_REG_W-1:0]);
				REG_IMAGE_HEIGHT: height_q <= height_eff(cfg_data[HEIGHT_REG_W-1:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (use_item) begin
			if (flags_in.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == width_last_q) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	assign s1_adv   = valid_s1 && (!produce_s1 || !out_valid_q || out_ready);
	assign s1_ready = !valid_s1 || s1_adv;
	assign in_ready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= use_item;
		end
	end

	always_ff @(posedge clk) begin
		if (use_item) begin
			col_s1     <= col_q;
			px_s1      <= draining ? '0 : pixel;
			produce_s1 <= produce_in;
			flags_s1   <= flags_in;
		end
	end

	// line stores: read at acceptance, written back as the request leaves s1
	always_ff @(posedge clk) begin
		if (use_item) begin
			cen_rd_s1 <= centre_mem[col_q];
		end
		if (s1_adv) begin
			centre_mem[col_s1] <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (use_item) begin
			abv_rd_s1 <= above_mem[col_q];
		end
		if (s1_adv) begin
			above_mem[col_s1] <= cen_rd_s1;
		end
	end

	assign win_clear = cfg_restart || (s1_adv && flags_s1.last);

	always_ff @(posedge clk) begin
		if (win_clear) begin
			up_q   <= '0;
			down_q <= '0;
		end else if (s1_adv) begin
			up_q   <= abv_rd_s1;
			down_q <= px_s1;
		end
	end

	lpf_tap_cell u_centre_cell (
		.clk   (clk),
		.shift (s1_adv),
		.clear (win_clear),
		.d     (cen_rd_s1),
		.q     (centre_px)
	);

	lpf_tap_cell u_left_cell (
		.clk   (clk),
		.shift (s1_adv),
		.clear (win_clear),
		.d     (centre_px),
		.q     (left_px)
	);

	lpf_stencil u_stencil (
		.clk       (clk),
		.load      (s1_adv && produce_s1),
		.centre    (centre_px),
		.left      (left_px),
		.right     (cen_rd_s1),
		.up        (up_q),
		.down      (down_q),
		.flags     (flags_s1),
		.filtered  (filtered),
		.frame_end (frame_end)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && produce_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	assign flush_drop   = in_acc && flush && !draining && !cfg_write;
	assign restart_due  = use_item && flags_in.last && !cfg_write;
	assign pos_in_frame = col_q <= width_last_q && row_q <= height_p1;

	`LPF_ASSERT_NEXT(a_flush_keeps_pos, flush_drop, $stable({col_q, row_q}), "flush moved position")
	`LPF_ASSERT_NEXT(a_restart_after_last, restart_due, {col_q, row_q} == '0, "no restart after last")
	`LPF_ASSERT_NOW(a_pos_bounds, 1'b1, pos_in_frame, "raster position outside frame")

endmodule

// File: sim/laplacian_four_neighbour_filter_top_tb.sv
class laplacian_scoreboard;
	typedef struct packed {
		logic [lpf_pkg::PIX_W-1:0] filtered;
		logic                      frame_end;
	} lap_result_t;

	logic [lpf_pkg::WIDTH_REG_W-1:0]  width_reg;
	logic [lpf_pkg::HEIGHT_REG_W-1:0] height_reg;
	logic [7:0]                       above_row [lpf_pkg::MAX_WIDTH];
	logic [7:0]                       centre_row [lpf_pkg::MAX_WIDTH];
	logic [23:0]                      window;
	logic [7:0]                       up_nb;
	logic [7:0]                       down_nb;
	int unsigned                      col_pos;
	int unsigned                      row_pos;
	lap_result_t                      expected_pixels [$];
	int unsigned                      mismatches;
	int unsigned                      checked;
	int unsigned                      frames_seen;

	function new();
		width_reg = lpf_pkg::WIDTH_RESET;
		height_reg = lpf_pkg::HEIGHT_RESET;
		foreach (above_row[i]) begin
			above_row[i] = 8'd0;
			centre_row[i] = 8'd0;
		end
		mismatches = 0;
		checked = 0;
		frames_seen = 0;
		restart_frame();
	endfunction

	function void restart_frame();
		window = 24'd0;
		up_nb = 8'd0;
		down_nb = 8'd0;
		col_pos = 0;
		row_pos = 0;
	endfunction

	function int unsigned eff_width();
		if (width_reg < lpf_pkg::MIN_WIDTH)
			return int'(lpf_pkg::MIN_WIDTH);
		if (width_reg > lpf_pkg::MAX_WIDTH)
			return lpf_pkg::MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function int unsigned eff_height();
		if (height_reg < lpf_pkg::MIN_HEIGHT)
			return int'(lpf_pkg::MIN_HEIGHT);
		return int'(height_reg);
	endfunction

	function void write_register(input logic [lpf_pkg::CFG_IDX_W-1:0] idx,
	                             input logic [lpf_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			lpf_pkg::REG_IMAGE_WIDTH: begin
				width_reg = data[lpf_pkg::WIDTH_REG_W-1:0];
				restart_frame();
			end
			lpf_pkg::REG_IMAGE_HEIGHT: begin
				height_reg = data[lpf_pkg::HEIGHT_REG_W-1:0];
				restart_frame();
			end
			default: ;
		endcase
	endfunction

	// returns 0 when the request is dropped (flush inside a frame)
	function bit predict_request(input logic [7:0] pix, input logic fl);
		int unsigned w, h, ci, ri, oc, orow;
		int          c, l, r, u, d, sum;
		bit          draining, last_px;
		logic [7:0]  px, col_val;
		lap_result_t res;
		w = eff_width();
		h = eff_height();
		ci = col_pos;
		ri = row_pos;
		last_px = 1'b0;
		draining = (ri >= h);
		if (fl && !draining)
			return 1'b0;
		px = draining ? 8'd0 : pix;
		col_val = centre_row[ci];
		if (ri >= 2 || (ri == 1 && ci != 0)) begin
			if (ci == 0) begin
				oc = w - 1;
				orow = ri - 2;
			end else begin
				oc = ci - 1;
				orow = ri - 1;
			end
			c = int'(window[7:0]);
			l = (oc == 0) ? 0 : int'(window[15:8]);
			r = (oc == w - 1) ? 0 : int'(col_val);
			u = (orow == 0) ? 0 : int'(up_nb);
			d = (orow == h - 1) ? 0 : int'(down_nb);
			sum = u + d + l + r - 4 * c + int'(lpf_pkg::LAP_OFFSET);
			if (sum < 0)
				sum = 0;
			if (sum > int'(lpf_pkg::PIX_MAX))
				sum = int'(lpf_pkg::PIX_MAX);
			last_px = (orow == h - 1) && (oc == w - 1);
			res.filtered = 8'(sum);
			res.frame_end = last_px;
			expected_pixels.push_back(res);
		end
		up_nb = above_row[ci];
		above_row[ci] = col_val;
		window = {window[15:0], col_val};
		centre_row[ci] = px;
		down_nb = px;
		ci++;
		if (ci >= w) begin
			ci = 0;
			ri++;
		end
		col_pos = ci;
		row_pos = ri;
		if (last_px)
			restart_frame();
		return 1'b1;
	endfunction

	task report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task check_pixel(input logic [7:0] f, input logic fe);
		lap_result_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch($sformatf("unexpected result filtered=%0d frame_end=%0b", f, fe));
			return;
		end
		want = expected_pixels.pop_front();
		checked++;
		if (f !== want.filtered)
			report_mismatch($sformatf("filtered %0d, expected %0d", f, want.filtered));
		if (fe !== want.frame_end)
			report_mismatch($sformatf("frame_end %0b, expected %0b", fe, want.frame_end));
		if (want.frame_end)
			frames_seen++;
	endtask
endclass

module laplacian_four_neighbour_filter_top_tb;
	import lpf_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_TARGET  = 720;
	localparam int LONG_HOLD      = 300;

	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int PIX_RANDOM  = 0;
	localparam int PIX_EXTREME = 1;
	localparam int PIX_MIDDLE  = 2;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [PIX_W-1:0]      pixel;
	logic                  flush;
	logic                  out_valid;
	logic                  out_ready;
	logic [PIX_W-1:0]      filtered;
	logic                  frame_end;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_request;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int unsigned requests_done;

	laplacian_scoreboard sb;

	laplacian_four_neighbour_filter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.flush     (flush),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered),
		.frame_end (frame_end),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check, then decide ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pixel(filtered, frame_end);
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_request - 1;
			hold_request = 0;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no request or result moved for %0d cycles", quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic logic [PIX_W-1:0] pick_pixel(input int mode);
		case (mode)
			PIX_EXTREME: return $urandom_range(1) ? PIX_MAX : 8'd0;
			PIX_MIDDLE:  return PIX_W'($urandom_range(100, 156));
			default:     return PIX_W'($urandom);
		endcase
	endfunction

	// entered and left at a rising edge; valid stays up after acceptance
	task automatic send_request(input logic [PIX_W-1:0] pix, input logic fl);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		pixel <= pix;
		flush <= fl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (sb.predict_request(pix, fl))
			requests_done++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
	                            input logic [CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.write_register(idx, data);
	endtask

	task automatic send_frame(input int mode, input bit noisy, input bit abandon);
		int unsigned w, h, n, cut;
		w = sb.eff_width();
		h = sb.eff_height();
		n = w * h;
		cut = abandon ? $urandom_range(n - 1, 1) : n;
		for (int unsigned k = 0; k < cut; k++) begin
			if (noisy && $urandom_range(9) == 0)
				send_request(PIX_W'($urandom), 1'b1);
			send_request(pick_pixel(mode), 1'b0);
		end
		if (!abandon)
			for (int unsigned k = 0; k <= w; k++)
				send_request(PIX_W'($urandom),
				             (noisy && $urandom_range(7) == 0) ? 1'b0 : 1'b1);
	endtask

	task automatic random_setting();
		logic [CFG_DATA_W-1:0] wdata, hdata;
		case ($urandom_range(9))
			0:       wdata = CFG_DATA_W'($urandom_range(2));
			1:       wdata = 12'h800 | CFG_DATA_W'($urandom_range(3, 8)); // top bit is dropped
			default: wdata = CFG_DATA_W'($urandom_range(3, 9));
		endcase
		if ($urandom_range(7) == 0)
			hdata = CFG_DATA_W'($urandom_range(1));
		else
			hdata = CFG_DATA_W'($urandom_range(2, 5));
		if ($urandom_range(9) == 0)
			set_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
		if ($urandom_range(1)) begin
			set_register(REG_IMAGE_WIDTH, wdata);
			set_register(REG_IMAGE_HEIGHT, hdata);
		end else begin
			set_register(REG_IMAGE_HEIGHT, hdata);
			set_register(REG_IMAGE_WIDTH, wdata);
		end
	endtask

	task automatic random_frames();
		int unsigned nframes;
		bit          abandon;
		random_setting();
		nframes = $urandom_range(1, 3);
		for (int unsigned f = 0; f < nframes; f++) begin
			abandon = ($urandom_range(7) == 0);
			send_frame($urandom_range(2), $urandom_range(3) == 0, abandon);
			if (abandon)
				break;
		end
	endtask

	initial begin
		int unsigned goal;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		pixel <= '0;
		flush <= 1'b0;
		out_ready <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		send_idle_pct = 31;
		recv_idle_pct = 77;
		hold_request = 0;
		requests_done = 0;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// partial frame at reset size, dropped by the width write
		send_request(8'd17, 1'b0);
		send_request(8'd200, 1'b0);
		send_request(8'd0, 1'b0);
		set_register(REG_IMAGE_WIDTH, 12'd0);
		set_register(REG_IMAGE_HEIGHT, 12'd1);
		set_register(REG_SPARE_A, 12'hABC);
		set_register(REG_SPARE_B, 12'h543);

		// 3x2 checkerboard saturates both ends; stray flush and a pixel while draining
		send_request(PIX_MAX, 1'b0);
		send_request(8'd0, 1'b0);
		send_request(8'd99, 1'b1);
		send_request(PIX_MAX, 1'b0);
		send_request(8'd0, 1'b0);
		send_request(PIX_MAX, 1'b0);
		send_request(8'd0, 1'b0);
		send_request(8'd0, 1'b1);
		send_request(8'hA5, 1'b0);
		send_request(8'd0, 1'b1);
		send_request(8'd0, 1'b1);
		// back to back frame, top row dark, bottom row bright
		send_request(8'd0, 1'b0);
		send_request(8'd0, 1'b0);
		send_request(8'd0, 1'b0);
		send_request(PIX_MAX, 1'b0);
		send_request(PIX_MAX, 1'b0);
		send_request(PIX_MAX, 1'b0);
		repeat (4) send_request(8'd0, 1'b1);

		// long output stall while the input keeps coming
		set_register(REG_IMAGE_WIDTH, 12'd8);
		set_register(REG_IMAGE_HEIGHT, 12'd5);
		hold_request = LONG_HOLD;
		send_frame(PIX_RANDOM, 1'b0, 1'b0);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 77;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			goal = requests_done + RANDOM_TARGET / 3;
			while (requests_done < goal)
				random_frames();
		end

		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d pixel and drain requests, checked %0d results over %0d whole frames",
		         requests_done, sb.checked, sb.frames_seen);
		$display("Sizes from clamped 3x2 to 9x5, dropped and spare writes, three stall mixes, %0d errors",
		         sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
